// ----- hw/rtl/sbuf_pkg.sv -----
// Shared constants and types for the ascending sort buffer.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package sbuf_pkg;

	// Default number of values one set may hold.
	localparam int CAPACITY_DEF = 16;

	// Width of one signed element.
	localparam int VAL_W = 32;

	// Operation that the control logic broadcasts to every cell.
	typedef struct packed {
		logic ins;    // insert the broadcast value at its sorted place
		logic shift;  // move every value one cell toward the head
	} sbuf_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sbuf_cell.sv -----
// One cell of the sorting chain: holds one value and its occupied flag.
// Depends on sbuf_pkg for the element width and the control struct.
`default_nettype none

module sbuf_cell (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire sbuf_pkg::sbuf_ctrl_t           ctrl,
	input  wire logic signed [sbuf_pkg::VAL_W-1:0] new_value,
	input  wire logic signed [sbuf_pkg::VAL_W-1:0] left_value,
	input  wire                                 left_occ,
	input  wire                                 left_gt,
	input  wire logic signed [sbuf_pkg::VAL_W-1:0] right_value,
	input  wire                                 right_occ,
	output logic signed [sbuf_pkg::VAL_W-1:0]   value,
	output logic                                occ,
	output logic                                gt
);
	import sbuf_pkg::*;

	logic signed [VAL_W-1:0] value_q;
	logic                    occ_q;

	// The new value belongs at or before this cell when the cell is empty
	// or holds a strictly greater value.
	assign gt    = !occ_q || (value_q > new_value);
	assign value = value_q;
	assign occ   = occ_q;

	// Occupied flag: an insert fills the first empty cell, a shift empties the tail.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctrl.ins) begin
			occ_q <= occ_q | left_occ;
		end else if (ctrl.shift) begin
			occ_q <= right_occ;
		end
	end

	// Value: on insert, a cell that is empty or greater takes the left neighbor's value
	// if it moves right, otherwise the new value, and other cells hold; on shift, take the right neighbor's value.
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (gt) begin
				value_q <= left_gt ? left_value : new_value;
			end
		end else if (ctrl.shift) begin
			value_q <= right_value;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/sort_buffer_ascending.sv -----
// Ascending sort buffer: a chain of compare cells keeps the set sorted as it loads.
// Load: one value per cycle; the item flagged last moves the block to drain.
// Drain: the state register switches after the last transfer, then each pop loads the
// output register, one result per cycle while out_ready is high; no input meanwhile.
// Reset clears the fill count, overflow flag and cell occupancy; held values
// are left undefined. Depends on sbuf_pkg and sbuf_cell.
`default_nettype none

module sort_buffer_ascending #(
	parameter int CAPACITY = sbuf_pkg::CAPACITY_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire logic signed [sbuf_pkg::VAL_W-1:0] value,
	input  wire                                 last,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic signed [sbuf_pkg::VAL_W-1:0]   value_res,
	output logic                                last_res,
	output logic                                dropped
);
	import sbuf_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

	localparam logic ST_LOAD  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic             state_q;
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic             out_valid_q;
	logic signed [VAL_W-1:0] value_res_q;
	logic             last_res_q;
	logic             dropped_q;

	logic signed [VAL_W-1:0] cell_val [CAPACITY];
	logic [CAPACITY-1:0]     cell_occ;
	logic [CAPACITY-1:0]     cell_gt;

	logic        in_xfer;
	logic        room;
	logic        pop;
	sbuf_ctrl_t  ctrl;

	// Handshake and chain control.
	assign in_ready = (state_q == ST_LOAD);
	assign in_xfer  = in_valid && in_ready;
	assign room     = (count_q != CAP_CNT);
	assign pop      = (state_q == ST_DRAIN) && (!out_valid_q || out_ready);
	assign ctrl.ins   = in_xfer && room;
	assign ctrl.shift = pop;

	// The chain of cells; the head cell sees a full, smaller neighbor on its left.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VAL_W-1:0] lv;
		logic signed [VAL_W-1:0] rv;
		logic lo;
		logic lg;
		logic ro;
		if (i == 0) begin : g_head
			assign lv = value;
			assign lo = 1'b1;
			assign lg = 1'b0;
		end else begin : g_mid
			assign lv = cell_val[i-1];
			assign lo = cell_occ[i-1];
			assign lg = cell_gt[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign rv = '0;
			assign ro = 1'b0;
		end else begin : g_body
			assign rv = cell_val[i+1];
			assign ro = cell_occ[i+1];
		end
		sbuf_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.new_value   (value),
			.left_value  (lv),
			.left_occ    (lo),
			.left_gt     (lg),
			.right_value (rv),
			.right_occ   (ro),
			.value       (cell_val[i]),
			.occ         (cell_occ[i]),
			.gt          (cell_gt[i])
		);
	end

	// Sequencer: fill count, overflow flag and load/drain state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (state_q == ST_LOAD) begin
			if (in_xfer) begin
				if (room) begin
					count_q <= count_q + ONE_CNT;
				end else begin
					ovf_q <= 1'b1;
				end
				if (last) begin
					state_q <= ST_DRAIN;
				end
			end
		end else if (pop) begin
			count_q <= count_q - ONE_CNT;
			if (count_q == ONE_CNT) begin
				state_q <= ST_LOAD;
				ovf_q   <= 1'b0;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload: the head cell's value leaves on each pop.
	always_ff @(posedge clk) begin
		if (pop) begin
			value_res_q <= cell_val[0];
			last_res_q  <= (count_q == ONE_CNT);
			dropped_q   <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign value_res = value_res_q;
	assign last_res  = last_res_q;
	assign dropped   = dropped_q;

	// The fill count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("fill count above capacity");

	// Occupied cells always match the fill count.
	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_occ) == int'(count_q))
		else $error("cell occupancy disagrees with fill count");

	// Draining never runs on an empty chain.
	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (count_q != '0))
		else $error("drain with empty chain");

	// Popping the final value returns the block to load with the set flagged last.
	a_final_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && count_q == ONE_CNT) |=> (state_q == ST_LOAD) && out_valid && last_res)
		else $error("final pop did not end the set");

endmodule

`default_nettype wire

// ----- test/sort_buffer_ascending_check.sv -----
// Scoreboard for the ascending sort buffer: watches both channels, predicts each set.
// Reports every mismatch and hands the failure and pending counts to the testbench top.
// Depends on sbuf_pkg.
`default_nettype none

module sort_buffer_ascending_check #(
	parameter int CAPACITY = sbuf_pkg::CAPACITY_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    in_valid,
	input  wire                                    in_ready,
	input  wire logic signed [sbuf_pkg::VAL_W-1:0] value,
	input  wire                                    last,
	input  wire                                    out_valid,
	input  wire                                    out_ready,
	input  wire logic signed [sbuf_pkg::VAL_W-1:0] value_res,
	input  wire                                    last_res,
	input  wire                                    dropped,
	output int                                     fail_count,
	output int                                     pending
);
	import sbuf_pkg::*;

	// One sorted element as it should leave the block.
	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    last;
		logic                    dropped;
	} sorted_entry_t;

	// Expected results in the order the block must emit them.
	sorted_entry_t sorted_q[$];

	// Predicted contents of the set being collected.
	logic signed [VAL_W-1:0] set_values [CAPACITY];
	int                      set_count;
	logic                    set_overflow;

	// Print one line per mismatch and count it.
	task automatic report(input string what, input sorted_entry_t got, input sorted_entry_t want);
		fail_count++;
		$display("ERROR %0t: %s: got value %0d last %b dropped %b, want %0d last %b dropped %b",
			$time, what, got.value, got.last, got.dropped,
			want.value, want.last, want.dropped);
	endtask

	// Check each result transfer, then fold each input transfer into the prediction.
	always @(posedge clk or negedge arst_n) begin : predict
		int                      j;
		int                      k;
		logic signed [VAL_W-1:0] swap;
		sorted_entry_t           got;
		sorted_entry_t           want;
		if (!arst_n) begin
			sorted_q.delete();
			set_count = 0;
			set_overflow = 1'b0;
			fail_count = 0;
			pending = 0;
		end else begin
			// A result transfer must match the oldest expected element.
			if (out_valid && out_ready) begin
				got = '{value_res, last_res, dropped};
				if (sorted_q.size() == 0) begin
					report("result with nothing expected", got, got);
				end else begin
					want = sorted_q.pop_front();
					if (got !== want) begin
						report("result mismatch", got, want);
					end
				end
			end

			// An input transfer stores the value unless the set is already full.
			if (in_valid && in_ready) begin
				if (set_count < CAPACITY) begin
					set_values[set_count] = value;
					set_count++;
				end else begin
					set_overflow = 1'b1;
				end

				// The last element closes the set: sort it and queue every element.
				if (last) begin
					for (j = 0; j + 1 < set_count; j++) begin
						for (k = 0; k + 1 < set_count - j; k++) begin
							if (set_values[k] > set_values[k + 1]) begin
								swap = set_values[k];
								set_values[k] = set_values[k + 1];
								set_values[k + 1] = swap;
							end
						end
					end
					for (k = 0; k < set_count; k++) begin
						sorted_q.push_back('{set_values[k], k == set_count - 1, set_overflow});
					end
					set_count = 0;
					set_overflow = 1'b0;
				end
			end
			pending = sorted_q.size();
		end
	end

endmodule

`default_nettype wire

// ----- test/sort_buffer_ascending_tb.sv -----
// Testbench top for the ascending sort buffer: clock, reset, set stimulus and verdict.
// Drives directed and random sets with bursty input and a stalling receiver.
// Depends on sbuf_pkg, sort_buffer_ascending and sort_buffer_ascending_check.
`default_nettype none

module sort_buffer_ascending_tb;
	import sbuf_pkg::*;

	localparam int CAPACITY  = CAPACITY_DEF;
	localparam int ITEMS     = 370;
	localparam int LIMIT     = 200000;
	localparam int HOLD_AT   = 300;
	localparam int LONG_HOLD = 400;
	localparam int SETTLE    = 2 * CAPACITY + 8;

	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

	// Receiver behavior over one stretch of cycles.
	typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE} rx_mode_t;

	// Kind of values that fill one random set.
	typedef enum int {SET_WIDE, SET_NARROW, SET_EXTREME, SET_MIXED} set_kind_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic signed [VAL_W-1:0] value = '0;
	logic                    last = 1'b0;
	logic                    out_ready = 1'b0;
	wire                     in_ready;
	wire                     out_valid;
	wire logic signed [VAL_W-1:0] value_res;
	wire                     last_res;
	wire                     dropped;
	int                      fail_count;
	int                      pending;
	int                      cycles = 0;
	int                      sent = 0;
	int                      burst_left = 0;

	always #10 clk = ~clk;

	sort_buffer_ascending #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value(value),
		.last(last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value_res(value_res),
		.last_res(last_res),
		.dropped(dropped)
	);

	sort_buffer_ascending_check #(
		.CAPACITY(CAPACITY)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value(value),
		.last(last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value_res(value_res),
		.last_res(last_res),
		.dropped(dropped),
		.fail_count(fail_count),
		.pending(pending)
	);

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("sort_buffer_ascending_tb failed");
			$finish;
		end
	end

	// Receiver: stretches of open, half-open and sparse ready, plus one long hold-off.
	initial begin : receiver
		rx_mode_t mode;
		int       span;
		int       ticks;
		mode = RX_OPEN;
		span = 0;
		ticks = 0;
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			ticks++;
			if (ticks == HOLD_AT) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if (span == 0) begin
				mode = rx_mode_t'($urandom_range(RX_OPEN, RX_SPARSE));
				span = $urandom_range(8, 64);
			end
			span--;
			case (mode)
				RX_OPEN: begin
					out_ready <= 1'b1;
				end
				RX_HALF: begin
					out_ready <= 1'($urandom_range(0, 1));
				end
				default: begin
					out_ready <= ($urandom_range(0, 3) == 0);
				end
			endcase
		end
	end

	// Offer one element and hold it until the transfer; bursts end in random gaps, some of zero length.
	task automatic send_item(input logic signed [VAL_W-1:0] v, input logic l);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		in_valid <= 1'b1;
		value <= v;
		last <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	// Draw one element for a set of the given kind.
	function automatic logic signed [VAL_W-1:0] pick_value(input set_kind_t kind);
		logic signed [VAL_W-1:0] pick;
		case (kind)
			SET_WIDE: begin
				pick = $urandom();
			end
			SET_NARROW: begin
				pick = $signed($urandom_range(0, 8)) - 4;
			end
			SET_EXTREME: begin
				case ($urandom_range(0, 4))
					0: pick = VAL_MIN;
					1: pick = VAL_MAX;
					2: pick = '0;
					3: pick = -1;
					default: pick = 1;
				endcase
			end
			default: begin
				pick = ($urandom_range(0, 1) == 0) ? $urandom() : pick_value(SET_EXTREME);
			end
		endcase
		return pick;
	endfunction

	// Main stimulus: directed sets, then random sets, then drain and verdict.
	initial begin : stimulus
		int        k;
		int        len;
		int        roll;
		set_kind_t kind;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single-element sets at both ends of the range.
		send_item(VAL_MIN, 1'b1);
		send_item(VAL_MAX, 1'b1);

		// Both extremes with a duplicate of the largest.
		send_item(VAL_MAX, 1'b0);
		send_item(VAL_MIN, 1'b0);
		send_item(VAL_MAX, 1'b1);

		// Descending set one past capacity; the dropped element is the last one.
		for (k = 0; k <= CAPACITY; k++) begin
			send_item(CAPACITY / 2 - k, k == CAPACITY);
		end

		// Random sets: mostly within capacity, some exactly full, some overflowing.
		while (sent < ITEMS) begin
			roll = $urandom_range(0, 9);
			if (roll < 7) begin
				len = $urandom_range(1, CAPACITY);
			end else if (roll == 7) begin
				len = CAPACITY;
			end else begin
				len = $urandom_range(CAPACITY + 1, CAPACITY + 6);
			end
			kind = set_kind_t'($urandom_range(SET_WIDE, SET_MIXED));
			for (k = 0; k < len; k++) begin
				send_item(pick_value(kind), k == len - 1);
			end
		end
		in_valid <= 1'b0;

		// Let the checker take in the final transfer, then wait for every expected element.
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("sort_buffer_ascending_tb passed");
		end else begin
			$display("sort_buffer_ascending_tb failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/sbuf_pkg.sv
hw/rtl/sbuf_cell.sv
hw/rtl/sort_buffer_ascending.sv
test/sort_buffer_ascending_check.sv
test/sort_buffer_ascending_tb.sv
